FILE: src/lennard_jones_periodic_force_core_assert.svh
// assertion macros for the lennard-jones force core
// expects i_clk and i_rst_n in the scope of use
`ifndef LENNARD_JONES_PERIODIC_FORCE_CORE_ASSERT_SVH
`define LENNARD_JONES_PERIODIC_FORCE_CORE_ASSERT_SVH

// same-cycle implication
`define LJPF_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ljpf check failed");

// next-cycle implication
`define LJPF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ljpf check failed");

`endif

FILE: src/ljpf_pkg.sv
// shared types and constants of the lennard-jones force core
// no dependencies
package ljpf_pkg;

    localparam int POS_W   = 32;
    localparam int FORCE_W = 48;
    localparam int SUM_W   = 57;
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 2;

    localparam logic [CFG_W-1:0] CFG_BOX_LENGTH     = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SIGMA_SQUARED  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_PARTICLE_COUNT = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_item;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_rsp;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OWN_CAP,
        ST_FETCH,
        ST_PAIR_CAP,
        ST_DIV,
        ST_MUL,
        ST_POST,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_MODX,
        OP_MODY,
        OP_SQX,
        OP_SQY,
        OP_RECIP,
        OP_T2,
        OP_T3,
        OP_T6,
        OP_PX,
        OP_FX,
        OP_PY,
        OP_FY
    } t_op;

endpackage

FILE: src/ljpf_div.sv
// restoring divider, 128 by 64 bit, one quotient bit per cycle
// depends on ljpf_pkg
module ljpf_div import ljpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num_hi,
    input  logic [63:0] i_num_lo,
    input  logic [63:0] i_den,
    output t_div_rsp    o_rsp,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_sat, n_sat;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_quot, n_quot;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic        ge;

    assign shifted = {r_rem, r_lo[63]};
    assign ge      = shifted >= {1'b0, i_den};
    assign diff    = shifted - {1'b0, i_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quot = r_quot;
        if (i_start) begin
            if (i_num_hi >= i_den) begin
                n_quot = '1;
                n_sat  = 1'b1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem  = i_num_hi;
                n_lo   = i_num_lo;
                n_quot = '0;
                n_sat  = 1'b0;
                n_cnt  = 7'd64;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem  = ge ? diff[63:0] : shifted[63:0];
            n_lo   = {r_lo[62:0], 1'b0};
            n_quot = {r_quot[62:0], ge};
            n_cnt  = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat  <= n_sat;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_quot     = r_quot;
    assign o_rem      = r_rem;

endmodule

FILE: src/ljpf_front.sv
// front end: accepts item beats into a two-entry queue for the back end
// depends on ljpf_pkg
module ljpf_front import ljpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_kind,
    input  logic [IDX_W-1:0] i_particle_index,
    input  logic [POS_W-1:0] i_pos_x,
    input  logic [POS_W-1:0] i_pos_y,
    input  logic             i_pop,
    output logic             o_item_valid,
    output t_item            o_item
);

    t_item      r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt;
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: i_kind, idx: i_particle_index,
                           pos_x: i_pos_x, pos_y: i_pos_y};
        end
    end

endmodule

FILE: src/ljpf_back.sv
// back end: position memory, pair force sequencer and result register
// depends on ljpf_pkg and ljpf_div
module ljpf_back import ljpf_pkg::*; #(
    parameter int MAX_PARTICLES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output t_back_stat         o_stat,
    input  logic [POS_W-1:0]   i_box_length,
    input  logic [POS_W-1:0]   i_sigma_squared,
    input  logic [CNT_W-1:0]   i_particle_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_result_index,
    output logic [FORCE_W-1:0] o_force_x,
    output logic [FORCE_W-1:0] o_force_y,
    output logic               o_saturated
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int KW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    function automatic logic [32:0] f_absdiff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] res;
        res = (a >= b) ? {1'b0, a - b} : {1'b1, b - a};
        return res;
    endfunction

    logic [63:0] mem [MAX_PARTICLES];
    logic [63:0] r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [KW-1:0]    r_k, n_k;
    logic [63:0]      r_own, n_own;
    logic [63:0]      r_pk, n_pk;
    logic             r_neg, n_neg;
    logic [31:0]      r_mx, n_mx, r_my, n_my;
    logic             r_sgx, n_sgx, r_sgy, n_sgy;
    logic [63:0]      r_r2, n_r2, r_t, n_t, r_t3, n_t3, r_g, n_g;
    logic             r_gneg, n_gneg;
    logic [SUM_W-1:0] r_sumx, n_sumx, r_sumy, n_sumy;
    logic             r_sat, n_sat;
    logic [63:0]      r_ma, n_ma, r_mb, n_mb;
    logic [2:0]       r_ms, n_ms;
    logic [127:0]     r_acc, n_acc;
    logic [63:0]      r_prod;
    logic             r_dstart, n_dstart;
    logic [63:0]      r_dhi, n_dhi, r_dlo, n_dlo, r_dden, n_dden;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [FORCE_W-1:0] r_out_fx, n_out_fx, r_out_fy, n_out_fy;
    logic             r_out_sat, n_out_sat;
    logic             pop;

    t_div_rsp    div_rsp;
    logic [63:0] div_quot, div_rem;

    logic [32:0]  len33;
    logic [KW-1:0] cnt_in, cnt_eff, item_idx_w, own_idx_w;
    logic [32:0]  rem33, img_diff;
    logic         rnd_up;
    logic [31:0]  img_mag;
    logic         mq_sat;
    logic [63:0]  mq;
    logic [63:0]  two_t6;
    logic         g_ge;
    logic [63:0]  gmag;
    logic         gneg;
    logic [97:0]  p3;
    logic [127:0] s_num;
    logic         f_over;
    logic [46:0]  fmag;
    logic [SUM_W-1:0] term;
    logic [2:0]   pj;
    logic [31:0]  mul_a, mul_b;
    logic         ovx, ovy;
    logic [FORCE_W-1:0] clx, cly;
    logic [32:0]  ad_x, ad_y;

    ljpf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_dstart),
        .i_num_hi (r_dhi),
        .i_num_lo (r_dlo),
        .i_den    (r_dden),
        .o_rsp    (div_rsp),
        .o_quot   (div_quot),
        .o_rem    (div_rem)
    );

    assign len33      = (i_box_length == '0) ? {1'b1, 32'd0} : {1'b0, i_box_length};
    assign cnt_in     = KW'(i_particle_count);
    assign cnt_eff    = (cnt_in > KW'(MAX_PARTICLES)) ? KW'(MAX_PARTICLES) : cnt_in;
    assign item_idx_w = KW'(i_item.idx);
    assign own_idx_w  = KW'(r_idx);

    assign rem33    = div_rem[32:0];
    assign rnd_up   = {rem33, 1'b0} >= {1'b0, len33};
    assign img_diff = len33 - rem33;
    assign img_mag  = rnd_up ? img_diff[31:0] : rem33[31:0];

    assign mq_sat = |r_acc[127:96];
    assign mq     = mq_sat ? '1 : r_acc[95:32];
    assign two_t6 = {mq[62:0], 1'b0};
    assign g_ge   = two_t6 >= r_t3;
    assign gmag   = mq[63] ? '1 : (g_ge ? two_t6 - r_t3 : r_t3 - two_t6);
    assign gneg   = !mq[63] && !g_ge;

    assign p3    = {2'b00, r_acc[95:0]} + {1'b0, r_acc[95:0], 1'b0};
    assign s_num = {11'd0, p3, 19'd0};

    assign f_over = |div_quot[63:47];
    assign fmag   = f_over ? '1 : div_quot[46:0];
    assign term   = {10'd0, fmag};

    assign ad_x = f_absdiff(r_own[31:0], r_rd_data[31:0]);
    assign ad_y = f_absdiff(r_own[63:32], r_pk[63:32]);

    assign ovx = (r_sumx[56:47] != '0) && (r_sumx[56:47] != '1);
    assign ovy = (r_sumy[56:47] != '0) && (r_sumy[56:47] != '1);
    assign clx = ovx ? (r_sumx[56] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : r_sumx[47:0];
    assign cly = ovy ? (r_sumy[56] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : r_sumy[47:0];

    assign pj    = r_ms - 3'd1;
    assign mul_a = r_ms[1] ? r_ma[63:32] : r_ma[31:0];
    assign mul_b = r_ms[0] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        n_state = r_state;  n_op = r_op;      n_idx = r_idx;    n_k = r_k;
        n_own = r_own;      n_pk = r_pk;      n_neg = r_neg;
        n_mx = r_mx;        n_my = r_my;      n_sgx = r_sgx;    n_sgy = r_sgy;
        n_r2 = r_r2;        n_t = r_t;        n_t3 = r_t3;      n_g = r_g;
        n_gneg = r_gneg;    n_sumx = r_sumx;  n_sumy = r_sumy;  n_sat = r_sat;
        n_ma = r_ma;        n_mb = r_mb;      n_ms = r_ms;      n_acc = r_acc;
        n_dstart = 1'b0;    n_dhi = r_dhi;    n_dlo = r_dlo;    n_dden = r_dden;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx = r_out_idx;  n_out_fx = r_out_fx;
        n_out_fy = r_out_fy;    n_out_sat = r_out_sat;
        pop     = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = item_idx_w[AW-1:0];
        rd_addr = r_k[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = item_idx_w[AW-1:0];
                if (i_item_valid) begin
                    pop = 1'b1;
                    if (i_item.kind == KIND_LOAD) begin
                        mem_we = item_idx_w < KW'(MAX_PARTICLES);
                    end else begin
                        n_idx   = i_item.idx;
                        n_k     = '0;
                        n_sumx  = '0;
                        n_sumy  = '0;
                        n_sat   = 1'b0;
                        n_state = ST_OWN_CAP;
                    end
                end
            end
            ST_OWN_CAP: begin
                n_own   = (own_idx_w < KW'(MAX_PARTICLES)) ? r_rd_data : '0;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (r_k >= cnt_eff) begin
                    n_state = ST_FINISH;
                end else begin
                    n_k = r_k + KW'(1);
                    if (r_k != own_idx_w) begin
                        n_state = ST_PAIR_CAP;
                    end
                end
            end
            ST_PAIR_CAP: begin
                n_pk     = r_rd_data;
                n_neg    = ad_x[32];
                n_dhi    = '0;
                n_dlo    = {32'd0, ad_x[31:0]};
                n_dden   = {31'd0, len33};
                n_dstart = 1'b1;
                n_op     = OP_MODX;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_POST;
                end
            end
            ST_MUL: begin
                if (r_ms != 3'd0) begin
                    case (pj[1:0]) inside
                        2'd0:       n_acc = r_acc + {64'd0, r_prod};
                        2'd1, 2'd2: n_acc = r_acc + {32'd0, r_prod, 32'd0};
                        default:    n_acc = r_acc + {r_prod, 64'd0};
                    endcase
                end
                n_ms = r_ms + 3'd1;
                if (r_ms == 3'd4) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                n_ms = 3'd0;
                unique case (r_op)
                    OP_MODX: begin
                        n_mx     = img_mag;
                        n_sgx    = r_neg ^ rnd_up;
                        n_neg    = ad_y[32];
                        n_dhi    = '0;
                        n_dlo    = {32'd0, ad_y[31:0]};
                        n_dden   = {31'd0, len33};
                        n_dstart = 1'b1;
                        n_op     = OP_MODY;
                        n_state  = ST_DIV;
                    end
                    OP_MODY: begin
                        n_my    = img_mag;
                        n_sgy   = r_neg ^ rnd_up;
                        n_ma    = {32'd0, r_mx};
                        n_mb    = {32'd0, r_mx};
                        n_acc   = '0;
                        n_op    = OP_SQX;
                        n_state = ST_MUL;
                    end
                    OP_SQX: begin
                        n_ma    = {32'd0, r_my};
                        n_mb    = {32'd0, r_my};
                        n_op    = OP_SQY;
                        n_state = ST_MUL;
                    end
                    OP_SQY: begin
                        if (r_acc[63:0] == '0) begin
                            n_sat   = 1'b1;
                            n_state = ST_FETCH;
                        end else begin
                            n_r2     = r_acc[63:0];
                            n_dhi    = {40'd0, i_sigma_squared[31:8]};
                            n_dlo    = {i_sigma_squared[7:0], 56'd0};
                            n_dden   = r_acc[63:0];
                            n_dstart = 1'b1;
                            n_op     = OP_RECIP;
                            n_state  = ST_DIV;
                        end
                    end
                    OP_RECIP: begin
                        n_sat   = r_sat | div_rsp.sat;
                        n_t     = div_quot;
                        n_ma    = div_quot;
                        n_mb    = div_quot;
                        n_acc   = '0;
                        n_op    = OP_T2;
                        n_state = ST_MUL;
                    end
                    OP_T2: begin
                        n_sat   = r_sat | mq_sat;
                        n_ma    = mq;
                        n_mb    = r_t;
                        n_acc   = '0;
                        n_op    = OP_T3;
                        n_state = ST_MUL;
                    end
                    OP_T3: begin
                        n_sat   = r_sat | mq_sat;
                        n_t3    = mq;
                        n_ma    = mq;
                        n_mb    = mq;
                        n_acc   = '0;
                        n_op    = OP_T6;
                        n_state = ST_MUL;
                    end
                    OP_T6: begin
                        n_sat   = r_sat | mq_sat | mq[63];
                        n_g     = gmag;
                        n_gneg  = gneg;
                        n_ma    = {32'd0, r_mx};
                        n_mb    = gmag;
                        n_acc   = '0;
                        n_op    = OP_PX;
                        n_state = ST_MUL;
                    end
                    OP_PX, OP_PY: begin
                        n_dhi    = s_num[127:64];
                        n_dlo    = s_num[63:0];
                        n_dden   = r_r2;
                        n_dstart = 1'b1;
                        n_op     = (r_op == OP_PX) ? OP_FX : OP_FY;
                        n_state  = ST_DIV;
                    end
                    OP_FX: begin
                        n_sat   = r_sat | f_over;
                        n_sumx  = (r_sgx ^ r_gneg) ? r_sumx - term : r_sumx + term;
                        n_ma    = {32'd0, r_my};
                        n_mb    = r_g;
                        n_acc   = '0;
                        n_op    = OP_PY;
                        n_state = ST_MUL;
                    end
                    OP_FY: begin
                        n_sat   = r_sat | f_over;
                        n_sumy  = (r_sgy ^ r_gneg) ? r_sumy - term : r_sumy + term;
                        n_state = ST_FETCH;
                    end
                    default: n_state = ST_FETCH;
                endcase
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_fx    = clx;
                    n_out_fy    = cly;
                    n_out_sat   = r_sat | ovx | ovy;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dstart    <= n_dstart;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_idx <= n_idx;     r_k <= n_k;
        r_own <= n_own;     r_pk <= n_pk;       r_neg <= n_neg;
        r_mx <= n_mx;       r_my <= n_my;       r_sgx <= n_sgx;   r_sgy <= n_sgy;
        r_r2 <= n_r2;       r_t <= n_t;         r_t3 <= n_t3;     r_g <= n_g;
        r_gneg <= n_gneg;   r_sumx <= n_sumx;   r_sumy <= n_sumy; r_sat <= n_sat;
        r_ma <= n_ma;       r_mb <= n_mb;       r_ms <= n_ms;     r_acc <= n_acc;
        r_dhi <= n_dhi;     r_dlo <= n_dlo;     r_dden <= n_dden;
        r_out_idx <= n_out_idx;  r_out_fx <= n_out_fx;
        r_out_fy <= n_out_fy;    r_out_sat <= n_out_sat;
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= {i_item.pos_y, i_item.pos_x};
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_stat.pop      = pop;
    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_index  = r_out_idx;
    assign o_force_x       = r_out_fx;
    assign o_force_y       = r_out_fy;
    assign o_saturated     = r_out_sat;

endmodule

FILE: src/lennard_jones_periodic_force_core.sv
// lennard-jones periodic force core: load beats are taken one per cycle while o_in_stall is low;
// a query sums one pair term (five divides, seven multiplies) per particle of the count
// clamped to MAX_PARTICLES, skipping the queried particle itself
// one query in flight at a time; coincident pairs and saturating divides finish early
// synchronous active-low reset clears control, presets config; position store not cleared.
// depends on ljpf_pkg, ljpf_front, ljpf_back and the assertion macro header
module lennard_jones_periodic_force_core import ljpf_pkg::*; #(
    parameter int MAX_PARTICLES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_particle_index,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_result_index,
    output logic [FORCE_W-1:0] o_force_x,
    output logic [FORCE_W-1:0] o_force_y,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [POS_W-1:0] r_box_length, n_box_length;
    logic [POS_W-1:0] r_sigma_sq, n_sigma_sq;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_item_valid;
    t_item            w_item;
    t_back_stat       w_stat;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_box_length = r_box_length;
        n_sigma_sq   = r_sigma_sq;
        n_count      = r_count;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOX_LENGTH:     n_box_length = i_cfg_data;
                CFG_SIGMA_SQUARED:  n_sigma_sq   = i_cfg_data;
                CFG_PARTICLE_COUNT: n_count      = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_length <= 32'd100663296;
            r_sigma_sq   <= 32'd5368709;
            r_count      <= 9'd225;
        end else begin
            r_box_length <= n_box_length;
            r_sigma_sq   <= n_sigma_sq;
            r_count      <= n_count;
        end
    end

    ljpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_particle_index (i_particle_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pop            (w_stat.pop),
        .o_item_valid     (w_item_valid),
        .o_item           (w_item)
    );

    ljpf_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (w_item_valid),
        .i_item           (w_item),
        .o_stat           (w_stat),
        .i_box_length     (r_box_length),
        .i_sigma_squared  (r_sigma_sq),
        .i_particle_count (r_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_index   (o_result_index),
        .o_force_x        (o_force_x),
        .o_force_y        (o_force_y),
        .o_saturated      (o_saturated)
    );

`include "lennard_jones_periodic_force_core_assert.svh"

    `LJPF_ASSERT_IMP(a_pop_has_item, w_stat.pop, w_item_valid)
    `LJPF_ASSERT_IMP(a_pop_only_idle, w_stat.pop, !w_stat.busy)
    `LJPF_ASSERT_IMP(a_stall_means_queued, o_in_stall, w_item_valid)
    `LJPF_ASSERT_IMP(a_result_after_work, $rose(o_out_valid), $past(w_stat.busy))

endmodule
